/* rtl/sdt_pkg.sv */
// Shared types, constants and command/status bundles of the slot dependency table.
package sdt_pkg;

    localparam int POOL_ENTRIES_DEF = 32;
    localparam int CHAIN_HEADS_DEF  = 4;

    localparam int PTR_W    = 6;
    localparam int SLOT_W   = 16;
    localparam int LOC_W    = 32;
    localparam int HASH_W   = 16;
    localparam int LIMIT_W  = 17;
    localparam int ACTION_W = 3;
    localparam int MODC_W   = 1;

    localparam logic [PTR_W-1:0]   NULL_PTR    = 6'd63;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

    localparam logic [ACTION_W-1:0] ACT_BUILD   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DISPOSE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHAIN   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_VISIT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ZAP     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CHECK   = 3'd5;

    localparam logic [1:0] KIND_DESTROY = 2'd0;
    localparam logic [1:0] KIND_VISITED = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_POOL  = 2'd2;

    typedef enum logic [2:0] {
        W_EMPTY_BUILD = 3'd0,
        W_EMPTY_ZAP   = 3'd1,
        W_FREEB       = 3'd2,
        W_FILE        = 3'd3,
        W_VISIT       = 3'd4,
        W_SCAN        = 3'd5,
        W_CHECK       = 3'd6,
        W_TAKE        = 3'd7
    } walk_t;

    typedef struct packed {
        logic       latch;
        logic       mod_step;
        logic       set_ch_slot;
        logic       set_ch_cursor;
        logic       clr_tries;
        logic       adv_cursor;
        logic       load;
        logic       rd;
        logic       act;
        walk_t      walk;
        logic       clr_damaged;
        logic       emit_status;
        logic       st_ok;
        logic [1:0] st_err;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                in_range;
        logic                mod_done;
        logic                cur_live;
        logic                free_live;
        logic                damaged;
        logic                tries_done;
        logic                scan_hit;
        logic                check_hit;
        logic                out_free;
    } stat_t;

endpackage

/* rtl/sdt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sdt_ctrl.sv */
// Controller state machine that sequences list walks for each action.
module sdt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sdt_pkg::stat_t stat,
    output sdt_pkg::cmd_t  cmd
);
    import sdt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MOD   = 8'b0000_0010,
        S_DISP  = 8'b0000_0100,
        S_BFREE = 8'b0000_1000,
        S_LOAD  = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_ACT   = 8'b0100_0000,
        S_STAT  = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    walk_t      walk_reg, walk_next;
    logic       st_ok_reg, st_ok_next;
    logic [1:0] st_err_reg, st_err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            walk_reg   <= W_VISIT;
            st_ok_reg  <= 1'b0;
            st_err_reg <= ERR_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            walk_reg   <= walk_next;
            st_ok_reg  <= st_ok_next;
            st_err_reg <= st_err_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd         = '0;
        cmd.walk    = walk_reg;
        state_next  = state_reg;
        walk_next   = walk_reg;
        st_ok_next  = st_ok_reg;
        st_err_next = st_err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.set_ch_slot = 1'b1;
                st_ok_next      = 1'b0;
                st_err_next     = ERR_NONE;
                state_next      = S_LOAD;
                unique case (stat.action)
                    ACT_BUILD:
                    begin
                        if (!stat.in_range)
                        begin
                            st_err_next = ERR_RANGE;
                            state_next  = S_STAT;
                        end
                        else
                        begin
                            cmd.clr_tries = 1'b1;
                            state_next    = S_BFREE;
                        end
                    end
                    ACT_DISPOSE: walk_next = W_FREEB;
                    ACT_CHAIN:   walk_next = stat.damaged ? W_FREEB : W_FILE;
                    ACT_VISIT:
                    begin
                        walk_next = W_VISIT;
                        if (!stat.in_range)
                        begin
                            st_err_next = ERR_RANGE;
                            state_next  = S_STAT;
                        end
                    end
                    ACT_ZAP:
                    begin
                        walk_next = W_EMPTY_ZAP;
                        if (!stat.in_range)
                        begin
                            st_err_next = ERR_RANGE;
                            state_next  = S_STAT;
                        end
                    end
                    ACT_CHECK:   walk_next = W_CHECK;
                    default:     state_next = S_STAT;
                endcase
            end
            S_BFREE:
            begin
                if (stat.free_live)
                begin
                    walk_next  = W_TAKE;
                    state_next = S_LOAD;
                end
                else if (stat.tries_done)
                begin
                    st_err_next = ERR_POOL;
                    state_next  = S_STAT;
                end
                else
                begin
                    cmd.set_ch_cursor = 1'b1;
                    walk_next         = W_EMPTY_BUILD;
                    state_next        = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (stat.cur_live)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_ACT;
                end
                else
                begin
                    state_next = S_STAT;
                    unique case (walk_reg)
                        W_EMPTY_BUILD:
                        begin
                            cmd.adv_cursor = 1'b1;
                            state_next     = S_BFREE;
                        end
                        W_EMPTY_ZAP:
                        begin
                            walk_next  = W_SCAN;
                            state_next = S_LOAD;
                        end
                        W_FREEB:  cmd.clr_damaged = 1'b1;
                        W_FILE:   st_ok_next = 1'b1;
                        W_CHECK:  st_ok_next = 1'b1;
                        default:  st_ok_next = 1'b0;
                    endcase
                end
            end
            S_ACT:
            begin
                if (!((walk_reg == W_EMPTY_BUILD || walk_reg == W_EMPTY_ZAP ||
                       walk_reg == W_VISIT) && !stat.out_free))
                begin
                    cmd.act    = 1'b1;
                    state_next = S_RD;
                    unique case (walk_reg)
                        W_SCAN:
                        begin
                            if (stat.scan_hit)
                            begin
                                state_next = S_STAT;
                            end
                        end
                        W_CHECK:
                        begin
                            if (stat.check_hit)
                            begin
                                state_next = S_STAT;
                            end
                        end
                        W_TAKE:  state_next = S_STAT;
                        default: state_next = S_RD;
                    endcase
                end
            end
            S_STAT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.st_ok       = st_ok_reg;
                    cmd.st_err      = st_err_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* rtl/sdt_datapath.sv */
// Datapath: entry memories, list heads, chain-number unit and output register.
module sdt_datapath #(
    parameter int POOL_ENTRIES = sdt_pkg::POOL_ENTRIES_DEF,
    parameter int CHAIN_HEADS  = sdt_pkg::CHAIN_HEADS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sdt_pkg::cmd_t                  cmd,
    output sdt_pkg::stat_t                 stat,
    input  logic [sdt_pkg::ACTION_W-1:0]   action,
    input  logic [sdt_pkg::SLOT_W-1:0]     slot,
    input  logic [sdt_pkg::LOC_W-1:0]      locator,
    input  logic [sdt_pkg::HASH_W-1:0]     entry_hash,
    input  logic                           cfg_valid,
    input  logic [sdt_pkg::LIMIT_W-1:0]    cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic [sdt_pkg::LOC_W-1:0]      out_locator,
    output logic [sdt_pkg::HASH_W-1:0]     out_hash,
    output logic                           ok,
    output logic [1:0]                     error,
    output logic                           last
);
    import sdt_pkg::*;

    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int CW = (CHAIN_HEADS > 1) ? $clog2(CHAIN_HEADS) : 1;
    localparam int TW = $clog2(CHAIN_HEADS + 1);
    localparam int SW = SLOT_W + CW;
    localparam int RK = SLOT_W + CW;
    localparam longint RECIP_L = ((longint'(1) << RK) + longint'(CHAIN_HEADS) - 1) /
                                 longint'(CHAIN_HEADS);
    localparam logic [RK:0]        RECIP    = (RK+1)'(RECIP_L);
    localparam logic [SLOT_W-1:0]  CH_S     = SLOT_W'(CHAIN_HEADS);
    localparam logic [CW-1:0]      CH_LAST  = CW'(CHAIN_HEADS - 1);
    localparam logic [TW-1:0]      CH_TRIES = TW'(CHAIN_HEADS);
    localparam logic [PTR_W-1:0]   POOL_C   = PTR_W'(POOL_ENTRIES);

    logic [ACTION_W-1:0] action_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [LOC_W-1:0]    loc_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic [CW-1:0]        rem_reg, rem_next;
    logic [MODC_W-1:0]    modc_reg;
    logic [SLOT_W-1:0]    quo_reg;
    logic [SLOT_W+RK-1:0] quo_prod;
    logic [SLOT_W-1:0]    quo_back, rem_full;

    logic [CW-1:0]    ch_reg;
    logic [CW-1:0]    cursor_reg;
    logic [TW-1:0]    tries_reg;
    logic [PTR_W-1:0] cur_reg, cur_next;
    logic [PTR_W-1:0] free_reg, free_next;
    logic [PTR_W-1:0] build_reg, build_next;
    logic             damaged_reg, damaged_next;
    logic [PTR_W-1:0] heads_reg [CHAIN_HEADS];
    logic [POOL_ENTRIES-1:0] nl_vld_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic             rd_vld_reg;

    logic             nl_we;
    logic [PTR_W-1:0] nl_wdata;
    logic             slot_we;
    logic             lh_we;
    logic             head_we;
    logic [CW-1:0]    head_idx;
    logic [PTR_W-1:0] head_wdata;
    logic [PTR_W-1:0] nl_q, nl_eff;
    logic [SW-1:0]    slot_q;
    logic [LOC_W-1:0] loc_q;
    logic [HASH_W-1:0] hash_q;
    logic [CW-1:0]    file_h;
    logic [AW-1:0]    cur_addr;

    logic              ov_reg;
    logic [1:0]        kind_reg;
    logic [LOC_W-1:0]  ol_reg;
    logic [HASH_W-1:0] oh_reg;
    logic              ok_reg;
    logic [1:0]        err_reg;
    logic              last_reg;
    logic              out_free;
    logic              emit_item;

    assign cur_addr = cur_reg[AW-1:0];
    assign file_h   = slot_q[SW-1:SLOT_W];
    assign out_free = !ov_reg || out_ready;

    // Chain number of the slot: the quotient comes from a reciprocal multiplication
    // in the first step, the remainder from a multiply-back and subtract in the second.
    assign quo_prod = {{RK{1'b0}}, slot_reg} * {{(SLOT_W-1){1'b0}}, RECIP};
    assign quo_back = quo_reg * CH_S;
    assign rem_full = slot_reg - quo_back;
    assign rem_next = rem_full[CW-1:0];

    // An entry whose link was never written still holds its reset link.
    assign nl_eff = rd_vld_reg ? nl_q :
                    ((rd_addr_reg == '0) ? NULL_PTR : PTR_W'(rd_addr_reg) - 1'b1);

    always_comb
    begin
        nl_we        = 1'b0;
        nl_wdata     = free_reg;
        slot_we      = 1'b0;
        lh_we        = 1'b0;
        head_we      = 1'b0;
        head_idx     = ch_reg;
        head_wdata   = nl_eff;
        emit_item    = 1'b0;
        cur_next     = cur_reg;
        free_next    = free_reg;
        build_next   = build_reg;
        damaged_next = damaged_reg;
        if (cmd.load)
        begin
            case (cmd.walk)
                W_FREEB, W_FILE, W_SCAN: cur_next = build_reg;
                W_TAKE:                  cur_next = free_reg;
                default:                 cur_next = heads_reg[ch_reg];
            endcase
        end
        if (cmd.act)
        begin
            cur_next = nl_eff;
            case (cmd.walk)
                W_EMPTY_BUILD, W_EMPTY_ZAP:
                begin
                    emit_item = 1'b1;
                    head_we   = 1'b1;
                    nl_we     = 1'b1;
                    free_next = cur_reg;
                end
                W_FREEB:
                begin
                    build_next = nl_eff;
                    nl_we      = 1'b1;
                    free_next  = cur_reg;
                end
                W_FILE:
                begin
                    build_next = nl_eff;
                    nl_we      = 1'b1;
                    nl_wdata   = heads_reg[file_h];
                    head_we    = 1'b1;
                    head_idx   = file_h;
                    head_wdata = cur_reg;
                    lh_we      = 1'b1;
                end
                W_VISIT:
                begin
                    emit_item = 1'b1;
                end
                W_SCAN:
                begin
                    if (stat.scan_hit)
                    begin
                        damaged_next = 1'b1;
                    end
                end
                W_TAKE:
                begin
                    free_next  = nl_eff;
                    nl_we      = 1'b1;
                    nl_wdata   = build_reg;
                    build_next = cur_reg;
                    slot_we    = 1'b1;
                end
                default: cur_next = nl_eff;
            endcase
        end
        if (cmd.clr_damaged)
        begin
            damaged_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= action;
            slot_reg   <= slot;
            loc_reg    <= locator;
            hash_reg   <= entry_hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            rem_reg     <= '0;
            modc_reg    <= '0;
            quo_reg     <= '0;
            ch_reg      <= '0;
            cursor_reg  <= '0;
            tries_reg   <= '0;
            cur_reg     <= NULL_PTR;
            free_reg    <= PTR_W'(POOL_ENTRIES - 1);
            build_reg   <= NULL_PTR;
            damaged_reg <= 1'b0;
            nl_vld_reg  <= '0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
            for (int i = 0; i < CHAIN_HEADS; i++)
            begin
                heads_reg[i] <= NULL_PTR;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.latch)
            begin
                rem_reg  <= '0;
                modc_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                if (modc_reg == '0)
                begin
                    quo_reg <= quo_prod[SLOT_W+RK-1:RK];
                end
                else
                begin
                    rem_reg <= rem_next;
                end
                modc_reg <= modc_reg + 1'b1;
            end
            if (cmd.set_ch_slot)
            begin
                ch_reg <= rem_reg;
            end
            else if (cmd.set_ch_cursor)
            begin
                ch_reg <= cursor_reg;
            end
            if (cmd.clr_tries)
            begin
                tries_reg <= '0;
            end
            else if (cmd.adv_cursor)
            begin
                tries_reg  <= tries_reg + 1'b1;
                cursor_reg <= (cursor_reg == CH_LAST) ? '0 : cursor_reg + 1'b1;
            end
            if (cmd.rd)
            begin
                rd_addr_reg <= cur_addr;
                rd_vld_reg  <= nl_vld_reg[cur_addr];
            end
            if (nl_we)
            begin
                nl_vld_reg[cur_addr] <= 1'b1;
            end
            if (head_we)
            begin
                heads_reg[head_idx] <= head_wdata;
            end
            cur_reg     <= cur_next;
            free_reg    <= free_next;
            build_reg   <= build_next;
            damaged_reg <= damaged_next;
        end
    end

    sdt_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_next_link (
        .clk   (clk),
        .we    (nl_we),
        .waddr (cur_addr),
        .wdata (nl_wdata),
        .re    (cmd.rd),
        .raddr (cur_addr),
        .rdata (nl_q)
    );

    sdt_ram #(.WIDTH(SW), .DEPTH(POOL_ENTRIES)) u_entry_slot (
        .clk   (clk),
        .we    (slot_we),
        .waddr (cur_addr),
        .wdata ({rem_reg, slot_reg}),
        .re    (cmd.rd),
        .raddr (cur_addr),
        .rdata (slot_q)
    );

    sdt_ram #(.WIDTH(LOC_W), .DEPTH(POOL_ENTRIES)) u_entry_locator (
        .clk   (clk),
        .we    (lh_we),
        .waddr (cur_addr),
        .wdata (loc_reg),
        .re    (cmd.rd),
        .raddr (cur_addr),
        .rdata (loc_q)
    );

    sdt_ram #(.WIDTH(HASH_W), .DEPTH(POOL_ENTRIES)) u_entry_hash (
        .clk   (clk),
        .we    (lh_we),
        .waddr (cur_addr),
        .wdata (hash_reg),
        .re    (cmd.rd),
        .raddr (cur_addr),
        .rdata (hash_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (emit_item || cmd.emit_status)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_item)
        begin
            kind_reg <= (cmd.walk == W_VISIT) ? KIND_VISITED : KIND_DESTROY;
            ol_reg   <= loc_q;
            oh_reg   <= hash_q;
            ok_reg   <= 1'b0;
            err_reg  <= ERR_NONE;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            kind_reg <= KIND_STATUS;
            ol_reg   <= '0;
            oh_reg   <= '0;
            ok_reg   <= cmd.st_ok;
            err_reg  <= cmd.st_err;
            last_reg <= 1'b1;
        end
    end

    always_comb
    begin
        stat.action     = action_reg;
        stat.in_range   = {1'b0, slot_reg} < limit_reg;
        stat.mod_done   = (modc_reg == '1);
        stat.cur_live   = cur_reg < POOL_C;
        stat.free_live  = free_reg < POOL_C;
        stat.damaged    = damaged_reg;
        stat.tries_done = (tries_reg == CH_TRIES);
        stat.scan_hit   = (slot_q[SLOT_W-1:0] == slot_reg);
        stat.check_hit  = (loc_q == loc_reg) && (hash_q == hash_reg);
        stat.out_free   = out_free;
    end

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign out_locator = ol_reg;
    assign out_hash    = oh_reg;
    assign ok          = ok_reg;
    assign error       = err_reg;
    assign last        = last_reg;

endmodule

/* rtl/slot_dependency_table_core.sv */
// Top level of the slot dependency table: controller plus datapath.
//
// Input channel (in_valid/in_ready) takes one action transaction at a time:
// action, slot, locator and entry_hash. Each action returns zero or more
// entry transactions (kind 0 destroyed, kind 1 visited) and then exactly one
// status transaction (kind 2) with last set, on the out_valid/out_ready channel.
// The cfg channel writes slot_limit; cfg_ready is always high.
// Sequence: the chain number of the slot is formed first, then dispatch and
// load, then each list entry walked takes one memory read and one update;
// a zap also scans the building list after emptying its chain, a build that
// finds no free entry empties chains in turn until one frees an entry, and an
// out-of-range slot in a build, visit or zap goes straight to its status. The
// entry memories have one read port, so every entry walked is read before it
// is updated.
// The next action is taken only after the status of the current one is
// loaded into the output register.
// When the receiver stalls, the walk holds on the entry being reported until
// the output register frees; nothing is dropped.
// At reset every entry is free in descending order, all chains are empty,
// slot_limit is 65536 and no clearing pass is needed.
module slot_dependency_table_core #(
    parameter int POOL_ENTRIES = sdt_pkg::POOL_ENTRIES_DEF,
    parameter int CHAIN_HEADS  = sdt_pkg::CHAIN_HEADS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sdt_pkg::ACTION_W-1:0]  action,
    input  logic [sdt_pkg::SLOT_W-1:0]    slot,
    input  logic [sdt_pkg::LOC_W-1:0]     locator,
    input  logic [sdt_pkg::HASH_W-1:0]    entry_hash,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [sdt_pkg::LOC_W-1:0]     out_locator,
    output logic [sdt_pkg::HASH_W-1:0]    out_hash,
    output logic                          ok,
    output logic [1:0]                    error,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sdt_pkg::LIMIT_W-1:0]   cfg_data
);
    import sdt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    sdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sdt_datapath #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .CHAIN_HEADS  (CHAIN_HEADS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .slot        (slot),
        .locator     (locator),
        .entry_hash  (entry_hash),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .out_locator (out_locator),
        .out_hash    (out_hash),
        .ok          (ok),
        .error       (error),
        .last        (last)
    );

endmodule
